[hdl/byte_spn_cipher_ecb_cbc_assert.svh]
// assertion macros for the byte cipher block
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef BYTE_SPN_CIPHER_ECB_CBC_ASSERT_SVH
`define BYTE_SPN_CIPHER_ECB_CBC_ASSERT_SVH

`ifndef SYNTHESIS

`define BSCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BSCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BSCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BSCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/bscc_pkg.sv]
// shared types, register indexes, s-box and rotate functions of the byte cipher
// no dependencies
package bscc_pkg;

  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] REG_CIPHER_KEY     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_DECRYPT_MODE   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_CHAIN_MODE     = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_INITIAL_VECTOR = 2'd3;

  typedef struct packed {
    logic [31:0] cipher_key;
    logic        decrypt_mode;
    logic        chain_mode;
    logic [7:0]  initial_vector;
  } cfg_t;

  localparam logic [3:0] SBOX_INV [16] = '{
    4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9, 4'd0,
    4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1, 4'd8
  };

  function automatic logic [3:0] sbox_nib(logic [3:0] x);
    logic [3:0] t;
    t = x + 4'd1;
    return 4'(t * 4'd7);
  endfunction

  function automatic logic [7:0] sub_fwd(logic [7:0] b);
    return {sbox_nib(b[7:4]), sbox_nib(b[3:0])};
  endfunction

  function automatic logic [7:0] sub_inv(logic [7:0] b);
    return {SBOX_INV[b[7:4]], SBOX_INV[b[3:0]]};
  endfunction

  function automatic logic [7:0] rotl2(logic [7:0] b);
    return {b[5:0], b[7:6]};
  endfunction

  function automatic logic [7:0] rotr2(logic [7:0] b);
    return {b[1:0], b[7:2]};
  endfunction

endpackage

[hdl/byte_spn_cipher_ecb_cbc.sv]
// top level of the byte cipher: config registers, input and result registers
// depends on bscc_pkg, bscc_core and byte_spn_cipher_ecb_cbc_assert.svh
//
// Usage:
//   Input beats (data_byte_i, start_of_message_i) are taken on in_valid_i with
//   in_stall_o low; result beats leave on out_valid_o, held while out_stall_i.
//   Config is written through cfg_we_i / cfg_index_i / cfg_wdata_i, one
//   register per cycle; the user must write only while no beat is in
//   flight, since the block itself does not enforce it. A beat taken into
//   the input register moves to the result register when that is free or
//   being read. Throughput: one beat per cycle while out_stall_i is low;
//   the cbc chain register closes its loop through the four-round datapath.
//   An input register and a result register sit back to back, so a new beat
//   is taken while a result waits; in_stall_o rises only when both are full
//   and the receiver stalls.
//   Reset clears all config registers, the chain value and both valid flags.
//   start_of_message_i makes a cbc beat chain from the initial vector.
`include "byte_spn_cipher_ecb_cbc_assert.svh"

module byte_spn_cipher_ecb_cbc
  import bscc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   start_of_message_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             result_byte_o
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_start_q;
  logic       out_valid_q;
  logic [7:0] out_result_q;
  logic [7:0] chain_q;
  logic [7:0] result_d;
  logic [7:0] chain_d;
  logic       advance;
  logic       in_take;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign result_byte_o = out_result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CIPHER_KEY:     cfg_q.cipher_key     <= cfg_wdata_i;
        REG_DECRYPT_MODE:   cfg_q.decrypt_mode   <= cfg_wdata_i[0];
        REG_CHAIN_MODE:     cfg_q.chain_mode     <= cfg_wdata_i[0];
        REG_INITIAL_VECTOR: cfg_q.initial_vector <= cfg_wdata_i[7:0];
      endcase
    end
  end

  bscc_core u_core (
    .cfg_i        (cfg_q),
    .data_i       (in_data_q),
    .start_i      (in_start_q),
    .chain_i      (chain_q),
    .result_o     (result_d),
    .chain_next_o (chain_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= 8'h00;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        chain_q     <= chain_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q  <= data_byte_i;
      in_start_q <= start_of_message_i;
    end
    if (advance) begin
      out_result_q <= result_d;
    end
  end

  `BSCC_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `BSCC_ASSERT_NEXT(a_enc_chain_is_result, clk_i, rst_ni, advance && !cfg_q.decrypt_mode, chain_q == out_result_q)
  `BSCC_ASSERT_NEXT(a_dec_chain_is_input, clk_i, rst_ni, advance && cfg_q.decrypt_mode, chain_q == $past(in_data_q))
  `BSCC_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q && out_stall_i)

endmodule

[hdl/bscc_core.sv]
// four-round byte cipher datapath with ecb/cbc mixing and chain update
// depends on bscc_pkg
module bscc_core
  import bscc_pkg::*;
(
  input  cfg_t       cfg_i,
  input  logic [7:0] data_i,
  input  logic       start_i,
  input  logic [7:0] chain_i,
  output logic [7:0] result_o,
  output logic [7:0] chain_next_o
);

  logic [7:0] k0, k1, k2, k3;
  logic [7:0] mix;
  logic [7:0] e0, e1, e2, e3;
  logic [7:0] d0, d1, d2;

  assign k0 = cfg_i.cipher_key[31:24];
  assign k1 = cfg_i.cipher_key[23:16];
  assign k2 = cfg_i.cipher_key[15:8];
  assign k3 = cfg_i.cipher_key[7:0];

  // chaining byte only counts in cbc mode
  assign mix = cfg_i.chain_mode ? (start_i ? cfg_i.initial_vector : chain_i) : 8'h00;

  // encrypt path
  assign e0 = data_i ^ mix ^ k0;
  assign e1 = rotl2(sub_fwd(e0)) ^ k1;
  assign e2 = rotl2(sub_fwd(e1)) ^ k2;
  assign e3 = sub_fwd(e2) ^ k3;

  // decrypt path
  assign d0 = sub_inv(data_i ^ k3);
  assign d1 = sub_inv(rotr2(d0 ^ k2));
  assign d2 = sub_inv(rotr2(d1 ^ k1));

  always_comb begin
    if (cfg_i.decrypt_mode) begin
      result_o     = d2 ^ k0 ^ mix;
      chain_next_o = data_i;
    end else begin
      result_o     = e3;
      chain_next_o = e3;
    end
  end

endmodule

[sim/tb_byte_spn_cipher_ecb_cbc.sv]
// testbench for byte_spn_cipher_ecb_cbc: directed script, then random cbc/ecb traffic
// under changing keys and modes, every result beat checked against an in-bench
// cipher or a pinned byte; depends on bscc_pkg and the byte_spn_cipher_ecb_cbc rtl
module tb_byte_spn_cipher_ecb_cbc;
  import bscc_pkg::*;

  localparam int QuietLimit   = 4000;
  localparam int ScriptLen    = 22;
  localparam int NumPhases    = 12;
  localparam int BeatsPerPhase = 108;
  localparam int LongHold     = 150;

  // one script row: either a register write or an input beat
  typedef struct packed {
    bit                   is_write;
    logic [CfgIdxWidth-1:0] reg_idx;
    logic [CfgWidth-1:0]  wdata;
    logic [7:0]           data;
    logic                 som;
    bit                   pinned;
    logic [7:0]           pin;
  } step_t;

  localparam logic [3:0] NibFwd [16] = '{
    4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1, 4'd8,
    4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9, 4'd0
  };
  localparam logic [3:0] NibInv [16] = '{
    4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9, 4'd0,
    4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1, 4'd8
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic [7:0]             data_byte = '0;
  logic                   som = 1'b0;
  logic                   out_stall = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [7:0]             result_byte_o;

  // typed expectation riding along with the beat
  logic                   pin_flag = 1'b0;
  logic [7:0]             pin_byte = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int errors = 0;

  // cipher state mirrored by the bench
  logic [31:0] p_key = '0;
  logic        p_decrypt = 1'b0;
  logic        p_cbc = 1'b0;
  logic [7:0]  p_iv = '0;
  logic [7:0]  p_chain = '0;

  logic [7:0] pending_bytes [$];

  byte_spn_cipher_ecb_cbc dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte),
    .start_of_message_i (som),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .result_byte_o      (result_byte_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] sub_nibbles(input logic [7:0] b, input logic inverse);
    if (inverse) begin
      return {NibInv[b[7:4]], NibInv[b[3:0]]};
    end
    return {NibFwd[b[7:4]], NibFwd[b[3:0]]};
  endfunction

  function automatic logic [7:0] spn_encrypt(input logic [7:0] b);
    logic [7:0] s;
    s = b ^ p_key[31:24];
    s = sub_nibbles(s, 1'b0);
    s = {s[5:0], s[7:6]} ^ p_key[23:16];
    s = sub_nibbles(s, 1'b0);
    s = {s[5:0], s[7:6]} ^ p_key[15:8];
    return sub_nibbles(s, 1'b0) ^ p_key[7:0];
  endfunction

  function automatic logic [7:0] spn_decrypt(input logic [7:0] b);
    logic [7:0] s;
    s = sub_nibbles(b ^ p_key[7:0], 1'b1);
    s = s ^ p_key[15:8];
    s = sub_nibbles({s[1:0], s[7:2]}, 1'b1);
    s = s ^ p_key[23:16];
    s = sub_nibbles({s[1:0], s[7:2]}, 1'b1);
    return s ^ p_key[31:24];
  endfunction

  // result of one beat; advances the chaining byte
  function automatic logic [7:0] cipher_beat(input logic [7:0] b, input logic start);
    logic [7:0] mix;
    logic [7:0] res;
    mix = p_cbc ? (start ? p_iv : p_chain) : 8'h00;
    if (p_decrypt) begin
      res = spn_decrypt(b) ^ mix;
      p_chain = b;
    end else begin
      res = spn_encrypt(b ^ mix);
      p_chain = res;
    end
    return res;
  endfunction

  function automatic step_t row_write(input logic [CfgIdxWidth-1:0] idx,
                                      input logic [CfgWidth-1:0] val);
    step_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.wdata = val;
    return r;
  endfunction

  function automatic step_t row_beat(input logic [7:0] d, input logic s,
                                     input bit pinned, input logic [7:0] pin);
    step_t r;
    r = '0;
    r.data = d;
    r.som = s;
    r.pinned = pinned;
    r.pin = pin;
    return r;
  endfunction

  // monitor: mirrors register writes, predicts accepted beats, checks results
  always @(posedge clk) begin : monitor
    logic [7:0] got;
    logic [7:0] want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CIPHER_KEY:     p_key = cfg_wdata[31:0];
          REG_DECRYPT_MODE:   p_decrypt = cfg_wdata[0];
          REG_CHAIN_MODE:     p_cbc = cfg_wdata[0];
          REG_INITIAL_VECTOR: p_iv = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall_o) begin
        got = cipher_beat(data_byte, som);
        pending_bytes.push_back(pin_flag ? pin_byte : got);
      end
      if (out_valid_o && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %02h", $time,
                   result_byte_o);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (want !== result_byte_o) begin
            $display("%0t: result_byte mismatch, expected %02h actual %02h", $time,
                     want, result_byte_o);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic [7:0] d, input logic s, input bit pinned,
                           input logic [7:0] pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    som <= s;
    pin_flag <= pinned;
    pin_byte <= pin;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    step_t script [ScriptLen];
    int n;
    int len;
    logic [7:0] d;
    logic s;
    logic [31:0] word;

    script = '{
      row_write(REG_CHAIN_MODE, 32'hFFFF_FFFF),      // wide value keeps bit 0 only
      row_beat(8'h00, 1'b0, 1'b1, 8'hFF),            // cbc right after reset chains from 0
      row_beat(8'hFF, 1'b0, 1'b0, 8'h00),
      row_beat(8'h5A, 1'b1, 1'b0, 8'h00),
      row_write(REG_INITIAL_VECTOR, 32'h1234_56FF),
      row_beat(8'h00, 1'b1, 1'b0, 8'h00),
      row_beat(8'h81, 1'b0, 1'b0, 8'h00),
      row_write(REG_CIPHER_KEY, 32'hFFFF_FFFF),
      row_beat(8'h00, 1'b1, 1'b0, 8'h00),
      row_beat(8'hFF, 1'b0, 1'b0, 8'h00),
      row_write(REG_DECRYPT_MODE, 32'h0000_0003),
      row_beat(8'h00, 1'b1, 1'b0, 8'h00),
      row_beat(8'hFF, 1'b0, 1'b0, 8'h00),
      row_beat(8'h7E, 1'b0, 1'b0, 8'h00),
      row_write(REG_CHAIN_MODE, 32'hFFFF_FFFE),
      row_write(REG_CIPHER_KEY, 32'h0000_0000),
      row_beat(8'hFF, 1'b1, 1'b1, 8'h00),            // ecb ignores the start mark
      row_beat(8'h22, 1'b0, 1'b1, 8'hFF),
      row_write(REG_DECRYPT_MODE, 32'hFFFF_FFFE),
      row_beat(8'h00, 1'b1, 1'b1, 8'hFF),
      row_beat(8'hFF, 1'b0, 1'b1, 8'h22),
      row_write(REG_INITIAL_VECTOR, 32'h0000_0000)
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 84;
    foreach (script[i]) begin
      if (script[i].is_write) begin
        wait_drain();
        write_reg(script[i].reg_idx, script[i].wdata);
      end else begin
        send_beat(script[i].data, script[i].som, script[i].pinned, script[i].pin);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drain();
      if (ph == 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 29;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: word = 32'h0000_0000;
        1: word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      write_reg(REG_CIPHER_KEY, word);
      write_reg(REG_DECRYPT_MODE, ($urandom & ~32'h1) | 32'(ph % 2));
      write_reg(REG_CHAIN_MODE, ($urandom & ~32'h1) | 32'((ph % 3) != 0));
      word = $urandom;
      case ($urandom_range(3))
        0: word[7:0] = 8'h00;
        1: word[7:0] = 8'hFF;
        default: ;
      endcase
      write_reg(REG_INITIAL_VECTOR, word);
      if (ph == 8) hold_req++;

      // messages of random length, each opened by a start mark, with some noise
      n = 0;
      while (n < BeatsPerPhase) begin
        len = $urandom_range(1, 16);
        for (int j = 0; j < len && n < BeatsPerPhase; j++) begin
          s = (j == 0);
          if ($urandom_range(99) < 8) s = 1'($urandom_range(1));
          case ($urandom_range(19))
            0: d = 8'h00;
            1: d = 8'hFF;
            default: d = 8'($urandom_range(255));
          endcase
          send_beat(d, s, 1'b0, 8'h00);
          n++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/bscc_pkg.sv
hdl/bscc_core.sv
hdl/byte_spn_cipher_ecb_cbc.sv
sim/tb_byte_spn_cipher_ecb_cbc.sv
